/* src/mst_pkg.sv */
package mst_pkg;

    // default number of octave rows in the tone table
    localparam int MST_OCTAVE_ROWS = 7;

    localparam int MST_CHAR_W  = 8;
    localparam int MST_FREQ_W  = 11;
    localparam int MST_DUR_W   = 16;
    localparam int MST_TEMPO_W = 10;
    localparam int MST_LEN_W   = 7;
    localparam int MST_DV_W    = 10;
    localparam int MST_CNT_W   = 2;
    // tempo times (length + 1), at most 1023 * 128
    localparam int MST_PROD_W  = 17;

    // quotient bits of the duration division, one per divider step
    localparam int MST_QUO_W  = 16;
    localparam int MST_STEP_W = $clog2(MST_QUO_W);

    localparam logic [MST_QUO_W-1:0] MST_DIVIDEND = 16'd60000;

    localparam logic [MST_TEMPO_W-1:0] MST_TEMPO_RST  = 10'd110;
    localparam logic [MST_LEN_W-1:0]   MST_LENGTH_RST = 7'd4;
    localparam int                     MST_OCTAVE_RST = 2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic out_load;
    } mst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic note_fire;
    } mst_status_t;

    // tone table, truncated to whole hertz; empty rows give 0
    function automatic logic [MST_FREQ_W-1:0] mst_tone_hz(
        input logic [2:0] octave,
        input logic [2:0] note
    );
        logic [MST_FREQ_W-1:0] hz;
        hz = '0;
        case (octave)
            3'd1:
            begin
                case (note)
                    3'd0: hz = 11'd130;
                    3'd1: hz = 11'd146;
                    3'd2: hz = 11'd164;
                    3'd3: hz = 11'd174;
                    3'd4: hz = 11'd196;
                    3'd5: hz = 11'd220;
                    3'd6: hz = 11'd246;
                    default: hz = 11'd130;
                endcase
            end
            3'd2:
            begin
                case (note)
                    3'd0: hz = 11'd261;
                    3'd1: hz = 11'd293;
                    3'd2: hz = 11'd329;
                    3'd3: hz = 11'd349;
                    3'd4: hz = 11'd392;
                    3'd5: hz = 11'd440;
                    3'd6: hz = 11'd493;
                    default: hz = 11'd261;
                endcase
            end
            3'd3:
            begin
                case (note)
                    3'd0: hz = 11'd523;
                    3'd1: hz = 11'd587;
                    3'd2: hz = 11'd659;
                    3'd3: hz = 11'd698;
                    3'd4: hz = 11'd783;
                    3'd5: hz = 11'd880;
                    3'd6: hz = 11'd987;
                    default: hz = 11'd523;
                endcase
            end
            3'd4:
            begin
                case (note)
                    3'd0: hz = 11'd1046;
                    3'd1: hz = 11'd1174;
                    3'd2: hz = 11'd1318;
                    3'd3: hz = 11'd1396;
                    3'd4: hz = 11'd1568;
                    3'd5: hz = 11'd1760;
                    3'd6: hz = 11'd1975;
                    default: hz = 11'd1046;
                endcase
            end
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage

/* src/mst_ctrl.sv */
module mst_ctrl
    import mst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  mst_status_t status,
    output mst_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [MST_STEP_W-1:0] STEP_LAST = MST_STEP_W'(MST_QUO_W - 1);

    logic [1:0]            state_reg, state_next;
    logic [MST_STEP_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.accept   = 1'b0;
        cmd.div_load = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.note_fire)
                begin
                    cmd.div_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // output register free or emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/mst_dp.sv */
module mst_dp
    import mst_pkg::*;
#(
    parameter int OCTAVE_ROWS = MST_OCTAVE_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MST_CHAR_W-1:0] char_code,
    input  mst_cmd_t              cmd,
    output mst_status_t           status,
    output logic [MST_FREQ_W-1:0] frequency_hz,
    output logic [MST_DUR_W-1:0]  duration_ms,
    output logic                  is_rest
);

    // octave register holds at least the reset octave
    localparam int OCT_W = ($clog2(OCTAVE_ROWS) > 2) ? $clog2(OCTAVE_ROWS) : 2;
    localparam logic [OCT_W-1:0]    OCT_MAX    = OCT_W'(OCTAVE_ROWS - 1);
    localparam logic [MST_DV_W-1:0] OCT_MAX_DV = MST_DV_W'(OCTAVE_ROWS - 1);

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_TEMPO  = 3'd1;
    localparam logic [2:0] KIND_OCTAVE = 3'd2;
    localparam logic [2:0] KIND_LENGTH = 3'd3;
    localparam logic [2:0] KIND_NOTE   = 3'd4;

    localparam logic [7:0] CH_UP   = 8'h3E;
    localparam logic [7:0] CH_DOWN = 8'h3C;
    localparam logic [7:0] CH_REST = 8'h2E;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_T    = 8'h54;

    localparam logic [2:0] NOTE_C = 3'd0;
    localparam logic [2:0] NOTE_D = 3'd1;
    localparam logic [2:0] NOTE_E = 3'd2;
    localparam logic [2:0] NOTE_F = 3'd3;
    localparam logic [2:0] NOTE_G = 3'd4;
    localparam logic [2:0] NOTE_A = 3'd5;
    localparam logic [2:0] NOTE_B = 3'd6;

    // melody state
    logic [OCT_W-1:0]       oct_reg, oct_next;
    logic [MST_TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [MST_LEN_W-1:0]   len_reg, len_next;
    logic [2:0]             kind_reg, kind_next;
    logic [2:0]             note_reg, note_next;
    logic                   rest_reg, rest_next;
    logic [MST_DV_W-1:0]    dv_reg, dv_next;
    logic [MST_CNT_W-1:0]   cnt_reg, cnt_next;

    // note held while dividing
    logic [MST_FREQ_W-1:0]  freq_hold_reg;
    logic                   rest_hold_reg;
    logic [MST_PROD_W-1:0]  den_reg;
    logic [MST_PROD_W-1:0]  rem_reg;
    logic [MST_QUO_W-1:0]   quo_reg;

    // output word
    logic [MST_FREQ_W-1:0]  freq_out_reg;
    logic [MST_DUR_W-1:0]   dur_out_reg;
    logic                   rest_out_reg;

    logic [7:0]             up_char;
    logic                   is_digit;
    logic                   pending;
    logic [3:0]             digit;
    logic [MST_DV_W+3:0]    dv_wide;
    logic [MST_DV_W-1:0]    dv_inc;
    logic [MST_CNT_W-1:0]   cnt_inc;
    logic [MST_CNT_W-1:0]   cnt_limit;
    logic                   finish;
    logic                   dispatch;
    logic [MST_DV_W-1:0]    fin_dv;
    logic [MST_CNT_W-1:0]   fin_cnt;
    logic [MST_LEN_W-1:0]   note_len;
    logic [MST_TEMPO_W-1:0] tempo_eff;
    logic [MST_PROD_W-1:0]  prod;
    logic [MST_PROD_W:0]    rem_shift;
    logic                   rem_ge;

    assign up_char  = (char_code >= CH_LO_A && char_code <= CH_LO_Z)
                      ? (char_code - 8'd32) : char_code;
    assign is_digit = (up_char >= CH_0) && (up_char <= CH_9);
    assign pending  = (kind_reg != KIND_NONE);
    assign digit    = 4'(up_char - CH_0);

    // value * 10 + digit as two shifts and two adds
    assign dv_wide   = ({4'b0, dv_reg} << 3) + ({4'b0, dv_reg} << 1)
                       + {{MST_DV_W{1'b0}}, digit};
    assign dv_inc    = dv_wide[MST_DV_W-1:0];
    assign cnt_inc   = cnt_reg + 1'b1;
    assign cnt_limit = (kind_reg == KIND_TEMPO) ? 2'd3 : 2'd2;

    always_comb
    begin
        oct_next   = oct_reg;
        tempo_next = tempo_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        note_next  = note_reg;
        rest_next  = rest_reg;
        dv_next    = dv_reg;
        cnt_next   = cnt_reg;
        finish     = 1'b0;
        dispatch   = 1'b0;
        fin_dv     = dv_reg;
        fin_cnt    = cnt_reg;

        if (pending && is_digit)
        begin
            dv_next  = dv_inc;
            cnt_next = cnt_inc;
            if (cnt_inc >= cnt_limit)
            begin
                finish  = 1'b1;
                fin_dv  = dv_inc;
                fin_cnt = cnt_inc;
            end
        end
        else
        begin
            finish   = pending;
            dispatch = 1'b1;
        end

        // complete the pending command
        if (finish)
        begin
            kind_next = KIND_NONE;
            dv_next   = '0;
            cnt_next  = '0;
            case (kind_reg)
                KIND_TEMPO:
                begin
                    if (fin_cnt != '0)
                    begin
                        tempo_next = fin_dv;
                    end
                end
                KIND_OCTAVE:
                begin
                    if (fin_cnt != '0)
                    begin
                        oct_next = (fin_dv > OCT_MAX_DV) ? OCT_MAX : fin_dv[OCT_W-1:0];
                    end
                end
                KIND_LENGTH:
                begin
                    if (fin_cnt != '0)
                    begin
                        len_next = fin_dv[MST_LEN_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end

        // then the character as a new command
        if (dispatch)
        begin
            case (up_char)
                CH_UP:
                begin
                    if (oct_next < OCT_MAX)
                    begin
                        oct_next = oct_next + 1'b1;
                    end
                end
                CH_DOWN:
                begin
                    if (oct_next != '0)
                    begin
                        oct_next = oct_next - 1'b1;
                    end
                end
                CH_T: kind_next = KIND_TEMPO;
                CH_O: kind_next = KIND_OCTAVE;
                CH_L: kind_next = KIND_LENGTH;
                CH_REST:
                begin
                    kind_next = KIND_NOTE;
                    note_next = NOTE_C;
                    rest_next = 1'b1;
                end
                CH_C, CH_D, CH_E, CH_F, CH_G, CH_A, CH_B:
                begin
                    kind_next = KIND_NOTE;
                    rest_next = 1'b0;
                    case (up_char)
                        CH_C: note_next = NOTE_C;
                        CH_D: note_next = NOTE_D;
                        CH_E: note_next = NOTE_E;
                        CH_F: note_next = NOTE_F;
                        CH_G: note_next = NOTE_G;
                        CH_A: note_next = NOTE_A;
                        default: note_next = NOTE_B;
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.note_fire = finish && (kind_reg == KIND_NOTE);

    // divisor for the note being completed
    assign note_len  = (fin_dv != '0) ? fin_dv[MST_LEN_W-1:0] : len_reg;
    assign tempo_eff = (tempo_reg != '0) ? tempo_reg : MST_TEMPO_W'(1);
    assign prod      = MST_PROD_W'(tempo_eff) * (MST_PROD_W'(note_len) + 1'b1);

    // restoring division, one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[MST_QUO_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg   <= OCT_W'(MST_OCTAVE_RST);
            tempo_reg <= MST_TEMPO_RST;
            len_reg   <= MST_LENGTH_RST;
            kind_reg  <= KIND_NONE;
            note_reg  <= NOTE_C;
            rest_reg  <= 1'b0;
            dv_reg    <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            oct_reg   <= oct_next;
            tempo_reg <= tempo_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
            note_reg  <= note_next;
            rest_reg  <= rest_next;
            dv_reg    <= dv_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            freq_hold_reg <= rest_reg ? '0 : mst_tone_hz(3'(oct_reg), note_reg);
            rest_hold_reg <= rest_reg;
            den_reg       <= prod;
            rem_reg       <= '0;
            quo_reg       <= MST_DIVIDEND;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? MST_PROD_W'(rem_shift - {1'b0, den_reg})
                              : rem_shift[MST_PROD_W-1:0];
            quo_reg <= {quo_reg[MST_QUO_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            freq_out_reg <= freq_hold_reg;
            dur_out_reg  <= (quo_reg == '0) ? MST_DUR_W'(1) : quo_reg;
            rest_out_reg <= rest_hold_reg;
        end
    end

    assign frequency_hz = freq_out_reg;
    assign duration_ms  = dur_out_reg;
    assign is_rest      = rest_out_reg;

endmodule

/* src/melody_string_tone_sequencer.sv */
// melody string tone sequencer: takes a melody string one character word at a
// time (lower case folded to upper) and gives one tone word for each note or
// rest it completes; '>' '<' step the octave, T O L set tempo, octave and
// default length, C D E F G A B play a note and '.' a rest, each optionally
// followed by digits, and a 0 character closes whatever command is open;
// a character that completes nothing is taken without holding the input, a
// character that completes a note holds the input while the block takes the
// word and forms tempo * (length + 1), runs the bit-per-cycle restoring
// divider that yields 60000 / (tempo * (length + 1)), and loads the output
// register, waiting as well while out_stall still holds the output register;
// a finished tone word waits in the output register while further characters
// that complete nothing keep being taken
module melody_string_tone_sequencer
    import mst_pkg::*;
#(
    // rows of the octave range, octave saturates at OCTAVE_ROWS - 1
    parameter int OCTAVE_ROWS = MST_OCTAVE_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // character input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MST_CHAR_W-1:0] char_code,
    // tone output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MST_FREQ_W-1:0] frequency_hz,
    output logic [MST_DUR_W-1:0]  duration_ms,
    output logic                  is_rest
);

    mst_cmd_t    cmd;
    mst_status_t status;

    // sequencing: handshakes, divider step count, output valid
    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // melody state, character decode, tone table, divider, output word
    mst_dp #(
        .OCTAVE_ROWS (OCTAVE_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .cmd          (cmd),
        .status       (status),
        .frequency_hz (frequency_hz),
        .duration_ms  (duration_ms),
        .is_rest      (is_rest)
    );

endmodule

/* src/mst_check.sv */
module mst_check
    import mst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [MST_FREQ_W-1:0] frequency_hz,
    input logic [MST_DUR_W-1:0]  duration_ms,
    input logic                  is_rest
);

    // a held tone word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frequency_hz)
            && $stable(duration_ms) && $stable(is_rest))
        else $error("tone word changed while stalled");

    // duration never truncates to zero
    a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duration_ms != '0)
        else $error("zero duration");

    // rests are silent
    a_rest_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_rest |-> frequency_hz == '0)
        else $error("rest with a frequency");

    // a new tone word only comes out of the divide, with the input held
    a_new_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("tone word without a divide");

endmodule

bind melody_string_tone_sequencer mst_check u_check (.*);

/* tb/mst_tone_checker.sv */
module mst_tone_checker
    import mst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [MST_CHAR_W-1:0] char_code,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [MST_FREQ_W-1:0] frequency_hz,
    input  logic [MST_DUR_W-1:0]  duration_ms,
    input  logic                  is_rest,
    output int                    fail_count,
    output int                    tones_waiting
);

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_TEMPO,
        PEND_OCTAVE,
        PEND_LENGTH,
        PEND_NOTE
    } pend_e;

    typedef struct packed {
        logic [MST_FREQ_W-1:0] freq;
        logic [MST_DUR_W-1:0]  dur;
        logic                  rest;
    } tone_t;

    localparam logic [7:0]  CH_END    = 8'h00;
    localparam logic [7:0]  CH_UP     = ">";
    localparam logic [7:0]  CH_DOWN   = "<";
    localparam logic [7:0]  CH_TEMPO  = "T";
    localparam logic [7:0]  CH_OCTAVE = "O";
    localparam logic [7:0]  CH_LENGTH = "L";
    localparam logic [7:0]  CH_REST   = ".";
    localparam logic [7:0]  CH_ZERO   = "0";
    localparam logic [7:0]  CH_NINE   = "9";
    localparam logic [7:0]  CH_LOW_A  = "a";
    localparam logic [7:0]  CH_LOW_Z  = "z";
    localparam logic [7:0]  CASE_BIT  = 8'h20;
    localparam logic [55:0] NOTE_NAMES = "CDEFGAB";
    localparam int          MAX_REPORTS = 10;
    localparam int          MS_PER_MINUTE = 60000;

    // whole-hertz pitches, rows 0 and 5..7 stay silent
    int tone_hz [0:7][0:6];

    initial
    begin
        tone_hz[1] = '{130, 146, 164, 174, 196, 220, 246};
        tone_hz[2] = '{261, 293, 329, 349, 392, 440, 493};
        tone_hz[3] = '{523, 587, 659, 698, 783, 880, 987};
        tone_hz[4] = '{1046, 1174, 1318, 1396, 1568, 1760, 1975};
    end

    logic [2:0]             octave_q;
    logic [MST_TEMPO_W-1:0] tempo_q;
    logic [MST_LEN_W-1:0]   def_len_q;
    pend_e                  pend_q;
    logic [2:0]             pend_note_q;
    logic                   pend_rest_q;
    logic [MST_DV_W-1:0]    digits_q;
    logic [MST_CNT_W-1:0]   ndigits_q;

    tone_t expected_tones [$];
    tone_t step_tone;
    tone_t seen_tone;
    bit    step_made;
    int    faults;

    task automatic close_command(output bit made, output tone_t t);
        int len;
        int bpm;
        int ms;
        made = 1'b0;
        t = '0;
        case (pend_q)
            PEND_TEMPO:
                if (ndigits_q != 0) tempo_q = digits_q;
            PEND_OCTAVE:
                if (ndigits_q != 0)
                    octave_q = (digits_q > MST_OCTAVE_ROWS - 1) ? 3'(MST_OCTAVE_ROWS - 1)
                                                                 : digits_q[2:0];
            PEND_LENGTH:
                if (ndigits_q != 0) def_len_q = digits_q[MST_LEN_W-1:0];
            PEND_NOTE:
            begin
                len = (digits_q != 0) ? int'(digits_q) : int'(def_len_q);
                bpm = (tempo_q != 0) ? int'(tempo_q) : 1;
                ms = MS_PER_MINUTE / (bpm * (len + 1));
                if (ms == 0) ms = 1;
                t.freq = pend_rest_q ? '0 : MST_FREQ_W'(tone_hz[octave_q][pend_note_q]);
                t.dur  = ms[MST_DUR_W-1:0];
                t.rest = pend_rest_q;
                made = 1'b1;
            end
            default: ;
        endcase
        pend_q = PEND_NONE;
        digits_q = '0;
        ndigits_q = '0;
    endtask

    task automatic open_command(input logic [7:0] c);
        pend_e kind;
        kind = PEND_NONE;
        case (c)
            CH_UP:     if (octave_q < MST_OCTAVE_ROWS - 1) octave_q = octave_q + 1'b1;
            CH_DOWN:   if (octave_q > 0) octave_q = octave_q - 1'b1;
            CH_TEMPO:  kind = PEND_TEMPO;
            CH_OCTAVE: kind = PEND_OCTAVE;
            CH_LENGTH: kind = PEND_LENGTH;
            CH_REST:
            begin
                kind = PEND_NOTE;
                pend_note_q = '0;
                pend_rest_q = 1'b1;
            end
            default:
                for (int i = 0; i < 7; i++)
                    if (c == NOTE_NAMES[55 - 8 * i -: 8])
                    begin
                        kind = PEND_NOTE;
                        pend_note_q = 3'(i);
                        pend_rest_q = 1'b0;
                    end
        endcase
        if (kind != PEND_NONE)
        begin
            pend_q = kind;
            digits_q = '0;
            ndigits_q = '0;
        end
    endtask

    task automatic melody_step(input logic [7:0] raw, output bit made, output tone_t t);
        logic [7:0] c;
        bit         is_num;
        made = 1'b0;
        t = '0;
        c = raw;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_BIT;
        is_num = (c >= CH_ZERO && c <= CH_NINE);
        if (pend_q != PEND_NONE && is_num)
        begin
            digits_q = MST_DV_W'(digits_q * 10 + (c - CH_ZERO));
            ndigits_q = ndigits_q + 1'b1;
            if (ndigits_q >= ((pend_q == PEND_TEMPO) ? 3 : 2)) close_command(made, t);
        end
        else
        begin
            if (pend_q != PEND_NONE) close_command(made, t);
            if (c != CH_END) open_command(c);
        end
    endtask

    task automatic report(input string what, input tone_t want, input tone_t got);
        if (faults < MAX_REPORTS)
            $display("%0t: %s: expected freq %0d dur %0d rest %0d, got freq %0d dur %0d rest %0d",
                     $time, what, want.freq, want.dur, want.rest, got.freq, got.dur, got.rest);
        faults++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_q    = 3'(MST_OCTAVE_RST);
            tempo_q     = MST_TEMPO_RST;
            def_len_q   = MST_LENGTH_RST;
            pend_q      = PEND_NONE;
            pend_note_q = '0;
            pend_rest_q = 1'b0;
            digits_q    = '0;
            ndigits_q   = '0;
            expected_tones.delete();
        end
        else
        begin
            // results first so a word cannot be matched against its own cause
            if (out_valid && !out_stall)
            begin
                seen_tone = '{freq: frequency_hz, dur: duration_ms, rest: is_rest};
                if (expected_tones.size() == 0)
                    report("unexpected tone", '0, seen_tone);
                else if (expected_tones[0] !== seen_tone)
                    report("tone mismatch", expected_tones.pop_front(), seen_tone);
                else
                    void'(expected_tones.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                melody_step(char_code, step_made, step_tone);
                if (step_made) expected_tones.push_back(step_tone);
            end
        end
        fail_count    <= faults;
        tones_waiting <= expected_tones.size();
    end

endmodule

/* tb/tb_melody_string_tone_sequencer.sv */
module tb_melody_string_tone_sequencer;
    import mst_pkg::*;

    // command characters that the stimulus builds on
    localparam logic [7:0]  CH_END     = 8'h00;
    localparam logic [7:0]  CH_HIGH    = 8'hFF;
    localparam logic [7:0]  CH_ZERO    = "0";
    localparam logic [7:0]  CASE_BIT   = 8'h20;
    localparam logic [55:0] NOTE_NAMES = "CDEFGAB";
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam int PHASE_CHARS = 255;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [MST_CHAR_W-1:0] char_code;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MST_FREQ_W-1:0] frequency_hz;
    logic [MST_DUR_W-1:0]  duration_ms;
    logic                  is_rest;

    int fail_count;
    int tones_waiting;
    int chars_sent = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    // long hold-off requests from the sender side, served by the receiver
    int hold_asks = 0;
    int holds_served = 0;
    int hold_left = 0;

    melody_string_tone_sequencer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frequency_hz (frequency_hz),
        .duration_ms  (duration_ms),
        .is_rest      (is_rest)
    );

    mst_tone_checker tone_watch
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frequency_hz  (frequency_hz),
        .duration_ms   (duration_ms),
        .is_rest       (is_rest),
        .fail_count    (fail_count),
        .tones_waiting (tones_waiting)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: random stall, or a long counted hold-off when one is asked for
    always @(posedge clk)
    begin
        if (holds_served != hold_asks)
        begin
            holds_served <= hold_asks;
            hold_left    <= LONG_HOLD;
            out_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    // offer one word, with random idle cycles first, and wait until taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'($urandom);
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // sender pauses until every tone still owed has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tones_waiting != 0) @(posedge clk);
    endtask

    // one well-formed command with random content, or a bit of noise
    task automatic send_token();
        int         pick;
        int         ndig;
        int         slot;
        logic [7:0] head;
        pick = $urandom_range(99);
        ndig = $urandom_range(2);
        slot = $urandom_range(6);
        if (pick < 45)
            head = NOTE_NAMES[55 - 8 * slot -: 8];
        else if (pick < 55)
            head = ".";
        else if (pick < 63)
        begin
            head = "T";
            ndig = $urandom_range(3);
        end
        else if (pick < 71)
            head = "O";
        else if (pick < 79)
            head = "L";
        else
        begin
            // octave steps, end of string and stray bytes take no digits
            ndig = 0;
            if (pick < 87)
                head = $urandom_range(1) ? ">" : "<";
            else if (pick < 91)
                head = CH_END;
            else
                head = 8'($urandom);
        end
        if (head >= "A" && head <= "Z" && $urandom_range(1)) head = head | CASE_BIT;
        send_char(head);
        repeat (ndig) send_char(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic random_melody(input int n);
        int stop_at;
        stop_at = chars_sent + n;
        while (chars_sent < stop_at) send_token();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tempo completing on its third digit, tiny durations
        // rounded up, lower case, octave saturation and '>' at the top,
        // a note of length zero, tempo zero, L0, end of string closing
        // commands, O without digits, stray digit, two-digit note length
        // closing on its own, the top byte value
        send_text("T999L99cO9>B0.T0");
        send_char(CH_END);
        send_text("L0,g");
        send_char(CH_END);
        send_text("O<<7E12");
        send_char(CH_HIGH);
        send_text("a");
        send_char(CH_END);
        drain();

        // sender idles often, receiver more often
        send_gap_pct  = 26;
        recv_gap_pct <= 57;
        random_melody(PHASE_CHARS);
        // long hold-off while full-length notes keep coming, backs up the input
        hold_asks <= hold_asks + 1;
        repeat (6) send_text("G34d07");
        random_melody(PHASE_CHARS);
        drain();

        // the other way round, with a pause for all tones midway
        send_gap_pct  = 57;
        recv_gap_pct <= 26;
        random_melody(PHASE_CHARS);
        drain();
        random_melody(PHASE_CHARS);
        drain();

        // back to back on both sides
        send_gap_pct  = 0;
        recv_gap_pct <= 0;
        random_melody(2 * PHASE_CHARS);
        drain();
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && tones_waiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
